### design/vfcs_pkg.sv
// Shared constants, codes and controller/datapath types for the frame condition scaler.
`default_nettype none

package vfcs_pkg;

    // Frame store geometry
    localparam int MAX_PIXELS = 524288;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int IDX_W      = $clog2(MAX_PIXELS + 1);

    // Field and register widths
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int GAIN_W     = 12;
    localparam int STEP_W     = 17;
    localparam int STEP_FRAC  = 16;
    localparam int LEVEL_W    = 16;
    localparam int SUM_W      = 44;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = CH_W + WEIGHT_W;
    localparam int LUMA_W     = PROD_W + 2;
    localparam int LIMIT_W    = LEVEL_W + IDX_W;
    localparam int LINADDR_W  = COORD_W + DIM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Luminance weights, Q0.16
    localparam logic [WEIGHT_W-1:0] W_RED = 16'd20224;
    localparam logic [WEIGHT_W-1:0] W_GRN = 16'd39938;
    localparam logic [WEIGHT_W-1:0] W_BLU = 16'd5374;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Register reset values
    localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = 13'd480;
    localparam logic [GAIN_W-1:0]  RST_GAIN_Q     = 12'd563;
    localparam logic [1:0]         RST_DEPTH_MODE = 2'd0;
    localparam logic [STEP_W-1:0]  RST_SCALE_STEP = 17'd65536;
    localparam logic [LEVEL_W-1:0] RST_DARK_LEVEL = 16'd1306;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_GAIN_Q     = 3'd2,
        REG_DEPTH_MODE = 3'd3,
        REG_SCALE_STEP = 3'd4,
        REG_DARK_LEVEL = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DEPTH_PASS = 2'd0,
        DEPTH_332  = 2'd1,
        DEPTH_444  = 2'd2,
        DEPTH_555  = 2'd3
    } depth_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input beat
        logic ld_mul;    // store pixel, weight channels, bump index
        logic ld_acc;    // add luminance into the sum
        logic ld_lim;    // form dark limit
        logic ld_cmp;    // verdict, emit status, restart frame
        logic rd_map;    // scale output coordinate
        logic rd_addr;   // bounds check and linear address
        logic rd_mem;    // frame store read
        logic rd_gain;   // channel gain
        logic rd_out;    // pack and emit
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage

`default_nettype wire

### design/video_frame_condition_scale_unit.sv
// Top level of the frame condition scaler: controller, datapath and checks.
`default_nettype none

// Frame condition scaler. A command beat is taken when start is high and busy
// is low. cmd = 0 loads the next source pixel into the frame store and adds its
// luminance to the running sum; cmd = 1 reads one output pixel. A load runs the
// weight multiply and accumulate steps; a load marked last also forms the dark
// limit and compares, and produces a status beat (is_status = 1, dark = new verdict)
// on done in the cycle after the compare step. A read runs coordinate scale, bounds and address
// multiply, frame store read, gain multiply, pack; its beat shows on done in the
// first idle cycle after the sequence, so a new command can be accepted in that
// same cycle. The block takes no new command until the steps of the last one
// are through. done is high
// for exactly one cycle per result and the receiver cannot stall it; pixel_out,
// is_status, dark and out_of_range are only meaningful while done is high.
// Loads beyond MAX_PIXELS are dropped but a last mark still reports. A read whose
// mapped coordinate is outside the source size or the frame store returns zero with
// out_of_range set. Configuration writes (wr_en, wr_index, wr_data) take effect
// at once and must only be issued while the block is idle.
module video_frame_condition_scale_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cmd,
    input  wire logic [vfcs_pkg::PIX_W-1:0]        pixel,
    input  wire logic [vfcs_pkg::COORD_W-1:0]      out_x,
    input  wire logic [vfcs_pkg::COORD_W-1:0]      out_y,
    input  wire logic                              last,
    input  wire logic                              wr_en,
    input  wire logic [vfcs_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [vfcs_pkg::CFG_DATA_W-1:0]   wr_data,
    output logic                                   done,
    output logic [vfcs_pkg::PIX_W-1:0]             pixel_out,
    output logic                                   is_status,
    output logic                                   dark,
    output logic                                   out_of_range
);
    import vfcs_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    vfcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    vfcs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .pixel        (pixel),
        .out_x        (out_x),
        .out_y        (out_y),
        .last         (last),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .pixel_out    (pixel_out),
        .is_status    (is_status),
        .dark         (dark),
        .out_of_range (out_of_range)
    );

    // A result beat is only ever emitted as the sequencer returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    // An accepted command always occupies the sequencer next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start a sequence");

    // Status beats carry no pixel and no range flag.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_status) |-> (pixel_out == '0 && !out_of_range))
        else $error("status beat carries pixel data");

    // Out-of-range reads return zero and are never status beats.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (pixel_out == '0 && !is_status))
        else $error("out-of-range read returned data");

endmodule

`default_nettype wire

### design/vfcs_ctrl.sv
// Sequencer for load and read commands of the frame condition scaler.
`default_nettype none

module vfcs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              cmd,
    input  vfcs_pkg::dp_stat_t     stat,
    output vfcs_pkg::dp_cmd_t      ctl,
    output logic                   busy
);
    import vfcs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_LD_MUL  = 10'b00_0000_0010,
        S_LD_ACC  = 10'b00_0000_0100,
        S_LD_LIM  = 10'b00_0000_1000,
        S_LD_CMP  = 10'b00_0001_0000,
        S_RD_MAP  = 10'b00_0010_0000,
        S_RD_ADDR = 10'b00_0100_0000,
        S_RD_MEM  = 10'b00_1000_0000,
        S_RD_GAIN = 10'b01_0000_0000,
        S_RD_OUT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = cmd ? S_RD_MAP : S_LD_MUL;
                end
            end
            S_LD_MUL:  state_next = S_LD_ACC;
            S_LD_ACC:  state_next = stat.last ? S_LD_LIM : S_IDLE;
            S_LD_LIM:  state_next = S_LD_CMP;
            S_LD_CMP:  state_next = S_IDLE;
            S_RD_MAP:  state_next = S_RD_ADDR;
            S_RD_ADDR: state_next = S_RD_MEM;
            S_RD_MEM:  state_next = S_RD_GAIN;
            S_RD_GAIN: state_next = S_RD_OUT;
            S_RD_OUT:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.capture = (state_reg == S_IDLE) && start;
        ctl.ld_mul  = (state_reg == S_LD_MUL);
        ctl.ld_acc  = (state_reg == S_LD_ACC);
        ctl.ld_lim  = (state_reg == S_LD_LIM);
        ctl.ld_cmp  = (state_reg == S_LD_CMP);
        ctl.rd_map  = (state_reg == S_RD_MAP);
        ctl.rd_addr = (state_reg == S_RD_ADDR);
        ctl.rd_mem  = (state_reg == S_RD_MEM);
        ctl.rd_gain = (state_reg == S_RD_GAIN);
        ctl.rd_out  = (state_reg == S_RD_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/vfcs_dp.sv
// Datapath of the frame condition scaler: registers, frame store, luma sum, map, gain, pack.
`default_nettype none

module vfcs_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  vfcs_pkg::dp_cmd_t                      ctl,
    output vfcs_pkg::dp_stat_t                     stat,
    input  wire logic [vfcs_pkg::PIX_W-1:0]        pixel,
    input  wire logic [vfcs_pkg::COORD_W-1:0]      out_x,
    input  wire logic [vfcs_pkg::COORD_W-1:0]      out_y,
    input  wire logic                              last,
    input  wire logic                              wr_en,
    input  wire logic [vfcs_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [vfcs_pkg::CFG_DATA_W-1:0]   wr_data,
    output logic                                   done,
    output logic [vfcs_pkg::PIX_W-1:0]             pixel_out,
    output logic                                   is_status,
    output logic                                   dark,
    output logic                                   out_of_range
);
    import vfcs_pkg::*;

    // configuration
    logic [DIM_W-1:0]   src_width_reg;
    logic [DIM_W-1:0]   src_height_reg;
    logic [GAIN_W-1:0]  gain_q_reg;
    logic [1:0]         depth_mode_reg;
    logic [STEP_W-1:0]  scale_step_reg;
    logic [LEVEL_W-1:0] dark_level_reg;

    // frame state
    logic [IDX_W-1:0]   load_index_reg;
    logic [SUM_W-1:0]   luma_sum_reg;
    logic               dark_flag_reg;

    // captured beat
    logic [PIX_W-1:0]   pixel_reg;
    logic [COORD_W-1:0] ox_reg;
    logic [COORD_W-1:0] oy_reg;
    logic               last_reg;

    // load path
    logic [PROD_W-1:0]  prod_r_reg, prod_g_reg, prod_b_reg;
    logic               kept_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               full;
    logic [LUMA_W-1:0]  luma;

    // read path
    logic [COORD_W-1:0]   sx_reg, sy_reg;
    logic [COORD_W+STEP_W-1:0] prod_x, prod_y;
    logic                 in_frame_reg;
    logic [LINADDR_W-1:0] lin_addr_reg;
    logic                 ok_reg;
    logic [PIX_W-1:0]     rd_data_reg;
    logic [CH_W-1:0]      gr_reg, gg_reg, gb_reg;
    logic [PIX_W-1:0]     packed_pix;

    // outputs
    logic               done_reg;
    logic [PIX_W-1:0]   pixel_out_reg;
    logic               is_status_reg;
    logic               dark_reg;
    logic               oor_reg;

    logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];

    function automatic logic [CH_W-1:0] apply_gain(input logic [CH_W-1:0] c,
                                                   input logic [GAIN_W-1:0] g);
        logic [CH_W+GAIN_W-1:0] p;
        begin
            p = c * g;
            if (g == '0)
                apply_gain = c;
            else if (|p[CH_W+GAIN_W-1:2*CH_W])
                apply_gain = CH_MAX;
            else
                apply_gain = p[2*CH_W-1:CH_W];
        end
    endfunction

    assign stat.last = last_reg;
    assign full      = (load_index_reg == IDX_W'(MAX_PIXELS));
    assign luma      = LUMA_W'(prod_r_reg) + LUMA_W'(prod_g_reg) + LUMA_W'(prod_b_reg);
    assign prod_x    = ox_reg * scale_step_reg;
    assign prod_y    = oy_reg * scale_step_reg;

    always_comb
    begin
        unique case (depth_t'(depth_mode_reg))
            DEPTH_332: packed_pix = {16'b0, gb_reg[7:6], gg_reg[7:5], gr_reg[7:5]};
            DEPTH_444: packed_pix = {12'b0, gb_reg[7:4], gg_reg[7:4], gr_reg[7:4]};
            DEPTH_555: packed_pix = {9'b0, gb_reg[7:3], gg_reg[7:3], gr_reg[7:3]};
            default:   packed_pix = {gb_reg, gg_reg, gr_reg};
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            gain_q_reg     <= RST_GAIN_Q;
            depth_mode_reg <= RST_DEPTH_MODE;
            scale_step_reg <= RST_SCALE_STEP;
            dark_level_reg <= RST_DARK_LEVEL;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SRC_WIDTH:  src_width_reg  <= wr_data[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= wr_data[DIM_W-1:0];
                REG_GAIN_Q:     gain_q_reg     <= wr_data[GAIN_W-1:0];
                REG_DEPTH_MODE: depth_mode_reg <= wr_data[1:0];
                REG_SCALE_STEP: scale_step_reg <= wr_data[STEP_W-1:0];
                REG_DARK_LEVEL: dark_level_reg <= wr_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // frame state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
            luma_sum_reg   <= '0;
            dark_flag_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.ld_cmp | ctl.rd_out;
            if (ctl.ld_mul && !full)
            begin
                load_index_reg <= load_index_reg + 1'b1;
            end
            if (ctl.ld_acc && kept_reg)
            begin
                luma_sum_reg <= luma_sum_reg + SUM_W'(luma);
            end
            if (ctl.ld_cmp)
            begin
                dark_flag_reg  <= (luma_sum_reg < {limit_reg, 8'b0});
                load_index_reg <= '0;
                luma_sum_reg   <= '0;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            pixel_reg <= pixel;
            ox_reg    <= out_x;
            oy_reg    <= out_y;
            last_reg  <= last;
        end
        if (ctl.ld_mul)
        begin
            prod_r_reg <= pixel_reg[7:0] * W_RED;
            prod_g_reg <= pixel_reg[15:8] * W_GRN;
            prod_b_reg <= pixel_reg[23:16] * W_BLU;
            kept_reg   <= !full;
        end
        if (ctl.ld_lim)
        begin
            limit_reg <= dark_level_reg * load_index_reg;
        end
        if (ctl.rd_map)
        begin
            sx_reg <= prod_x[COORD_W+STEP_FRAC-1:STEP_FRAC];
            sy_reg <= prod_y[COORD_W+STEP_FRAC-1:STEP_FRAC];
        end
        if (ctl.rd_addr)
        begin
            in_frame_reg <= (DIM_W'(sx_reg) < src_width_reg) &&
                            (DIM_W'(sy_reg) < src_height_reg);
            lin_addr_reg <= LINADDR_W'(sy_reg * src_width_reg) + LINADDR_W'(sx_reg);
        end
        if (ctl.rd_mem)
        begin
            ok_reg <= in_frame_reg && (lin_addr_reg < LINADDR_W'(MAX_PIXELS));
        end
        if (ctl.rd_gain)
        begin
            gr_reg <= apply_gain(rd_data_reg[7:0], gain_q_reg);
            gg_reg <= apply_gain(rd_data_reg[15:8], gain_q_reg);
            gb_reg <= apply_gain(rd_data_reg[23:16], gain_q_reg);
        end
        if (ctl.ld_cmp)
        begin
            pixel_out_reg <= '0;
            is_status_reg <= 1'b1;
            dark_reg      <= (luma_sum_reg < {limit_reg, 8'b0});
            oor_reg       <= 1'b0;
        end
        else if (ctl.rd_out)
        begin
            pixel_out_reg <= ok_reg ? packed_pix : '0;
            is_status_reg <= 1'b0;
            dark_reg      <= dark_flag_reg;
            oor_reg       <= !ok_reg;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.ld_mul && !full)
        begin
            frame_mem[load_index_reg[ADDR_W-1:0]] <= pixel_reg;
        end
        if (ctl.rd_mem)
        begin
            rd_data_reg <= frame_mem[lin_addr_reg[ADDR_W-1:0]];
        end
    end

    assign done         = done_reg;
    assign pixel_out    = pixel_out_reg;
    assign is_status    = is_status_reg;
    assign dark         = dark_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire
